/* rtl/assert_macros.svh */
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond)
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

/* rtl/qrvt_pkg.sv */
// types and constants of the quaternion vertex transform
`timescale 1ns / 1ps

package qrvt_pkg;

  localparam int QUAT_W  = 18;  // quaternion component, Q2.16
  localparam int COORD_W = 32;  // vertex / shift coordinate, Q16.16
  localparam int PROD_W  = 36;  // quaternion product
  localparam int MAT_W   = 38;  // matrix entry, Q6.32
  localparam int MHI_W   = 22;  // matrix entry high part
  localparam int MLO_W   = 16;  // matrix entry low part
  localparam int CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] REG_QUAT_W  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_QUAT_X  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_QUAT_Y  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_QUAT_Z  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SHIFT_Y = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SHIFT_Z = 3'd6;

  localparam logic signed [QUAT_W-1:0] QUAT_W_RST = 18'sd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } vtx_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] moved_x;
    logic signed [COORD_W-1:0] moved_y;
    logic signed [COORD_W-1:0] moved_z;
    logic                      clipped;
  } vtx_out_t;

  // load enables of the row datapath stages
  typedef struct packed {
    logic mul;
    logic sum;
    logic fin;
  } row_en_t;

endpackage

/* rtl/qrvt_matrix.sv */
// quaternion registers and the derived rotation matrix, split into high and low parts
`timescale 1ns / 1ps

module qrvt_matrix import qrvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]       cfg_wdata,
  output logic signed [MHI_W-1:0]  mat_hi [3][3],
  output logic [MLO_W-1:0]         mat_lo [3][3]
);

  localparam logic signed [MAT_W-1:0] ONE = 38'sd4294967296;

  logic signed [QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [QUAT_W-1:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;

  // products indexed xx yy zz xy xz yz wx wy wz
  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [MAT_W-1:0]  e [9];
  logic signed [MAT_W-1:0]  m [3][3];
  logic signed [MHI_W-1:0]  mhi_r [3][3];
  logic [MLO_W-1:0]         mlo_r [3][3];

  always_comb begin
    qw_nxt = qw_r;
    qx_nxt = qx_r;
    qy_nxt = qy_r;
    qz_nxt = qz_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_QUAT_W: qw_nxt = cfg_wdata[QUAT_W-1:0];
        REG_QUAT_X: qx_nxt = cfg_wdata[QUAT_W-1:0];
        REG_QUAT_Y: qy_nxt = cfg_wdata[QUAT_W-1:0];
        REG_QUAT_Z: qz_nxt = cfg_wdata[QUAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r <= QUAT_W_RST;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else begin
      qw_r <= qw_nxt;
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
      qz_r <= qz_nxt;
    end
  end

  // products taken from the incoming write so the matrix settles early
  always_ff @(posedge clk) begin
    prod_r[0] <= PROD_W'(qx_nxt) * PROD_W'(qx_nxt);
    prod_r[1] <= PROD_W'(qy_nxt) * PROD_W'(qy_nxt);
    prod_r[2] <= PROD_W'(qz_nxt) * PROD_W'(qz_nxt);
    prod_r[3] <= PROD_W'(qx_nxt) * PROD_W'(qy_nxt);
    prod_r[4] <= PROD_W'(qx_nxt) * PROD_W'(qz_nxt);
    prod_r[5] <= PROD_W'(qy_nxt) * PROD_W'(qz_nxt);
    prod_r[6] <= PROD_W'(qw_nxt) * PROD_W'(qx_nxt);
    prod_r[7] <= PROD_W'(qw_nxt) * PROD_W'(qy_nxt);
    prod_r[8] <= PROD_W'(qw_nxt) * PROD_W'(qz_nxt);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = MAT_W'(prod_r[i]);
    end
    m[0][0] = ONE - ((e[1] + e[2]) <<< 1);
    m[0][1] = (e[3] - e[8]) <<< 1;
    m[0][2] = (e[4] + e[7]) <<< 1;
    m[1][0] = (e[3] + e[8]) <<< 1;
    m[1][1] = ONE - ((e[0] + e[2]) <<< 1);
    m[1][2] = (e[5] - e[6]) <<< 1;
    m[2][0] = (e[4] - e[7]) <<< 1;
    m[2][1] = (e[5] + e[6]) <<< 1;
    m[2][2] = ONE - ((e[0] + e[1]) <<< 1);
  end

  // high part is floor(m / 2^16), low part the remainder
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mhi_r[i][j] <= m[i][j][MAT_W-1:MLO_W];
        mlo_r[i][j] <= m[i][j][MLO_W-1:0];
      end
    end
  end

  assign mat_hi = mhi_r;
  assign mat_lo = mlo_r;

endmodule

/* rtl/qrvt_row.sv */
// one matrix row: products, sums, rounding, translation and saturation
`timescale 1ns / 1ps

module qrvt_row import qrvt_pkg::*; (
  input  logic                      clk,
  input  row_en_t                   en,
  input  logic signed [MHI_W-1:0]   mhi [3],
  input  logic [MLO_W-1:0]          mlo [3],
  input  logic signed [COORD_W-1:0] vtx [3],
  input  logic signed [COORD_W-1:0] shift,
  output logic signed [COORD_W-1:0] moved,
  output logic                      clip
);

  localparam int PH_W  = MHI_W + COORD_W;        // 54
  localparam int PL_W  = MLO_W + 1 + COORD_W;    // 49
  localparam int A_W   = PH_W + 2;
  localparam int B_W   = PL_W + 2;
  localparam int ACC_W = A_W + 1;
  localparam int RND_W = ACC_W - MLO_W;
  localparam int RES_W = RND_W + 1;

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(32768);
  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(64'sh7FFFFFFF);
  localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(64'sh80000000);

  logic signed [PH_W-1:0]  ph_r [3];
  logic signed [PL_W-1:0]  pl_r [3];
  logic signed [A_W-1:0]   a_r;
  logic signed [B_W-1:0]   b_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [RND_W-1:0] rnd;
  logic signed [RES_W-1:0] res;
  logic signed [COORD_W-1:0] moved_r, moved_nxt;
  logic                      clip_r, clip_nxt;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= PH_W'(mhi[j]) * PH_W'(vtx[j]);
        pl_r[j] <= PL_W'($signed({1'b0, mlo[j]})) * PL_W'(vtx[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      a_r <= A_W'(ph_r[0]) + A_W'(ph_r[1]) + A_W'(ph_r[2]);
      b_r <= B_W'(pl_r[0]) + B_W'(pl_r[1]) + B_W'(pl_r[2]);
    end
  end

  // round half up to Q16.16, then add the translation and clamp
  always_comb begin
    acc = ACC_W'(a_r) + ACC_W'(b_r >>> MLO_W) + HALF;
    rnd = acc[ACC_W-1:MLO_W];
    res = RES_W'(rnd) + RES_W'(shift);
    if (res > SAT_MAX) begin
      moved_nxt = SAT_MAX[COORD_W-1:0];
      clip_nxt  = 1'b1;
    end else if (res < SAT_MIN) begin
      moved_nxt = SAT_MIN[COORD_W-1:0];
      clip_nxt  = 1'b1;
    end else begin
      moved_nxt = res[COORD_W-1:0];
      clip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.fin) begin
      moved_r <= moved_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign moved = moved_r;
  assign clip  = clip_r;

endmodule

/* rtl/quaternion_rigid_vertex_transform.sv */
// throughput: one vertex per cycle while out_stall is low, set by the five-stage datapath
// its stages are input, skew, multiply, sum and output register, with one multiply stage
// each stage advances when the stage after it is empty or moving, so bubbles close up
// a quaternion write rebuilds the rotation matrix through its product and matrix registers
// reset (synchronous, active low) empties the pipeline and sets identity rotation, zero shift
`timescale 1ns / 1ps

`include "assert_macros.svh"

module quaternion_rigid_vertex_transform import qrvt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vtx_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vtx_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0] cfg_wdata
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] rdy;

  vtx_in_t s0_r, s1_r;
  logic signed [COORD_W-1:0] vtx [3];

  logic signed [COORD_W-1:0] shx_r, shy_r, shz_r;

  logic signed [MHI_W-1:0] mat_hi [3][3];
  logic [MLO_W-1:0]        mat_lo [3][3];

  row_en_t en;
  logic signed [COORD_W-1:0] mv_x, mv_y, mv_z;
  logic                      cl_x, cl_y, cl_z;

  // per-stage ready, from the output backwards
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // input register and a skew stage that lines up with the matrix update
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_r <= in_data;
    end
    if (rdy[1]) begin
      s1_r <= s0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shx_r <= '0;
      shy_r <= '0;
      shz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHIFT_X: shx_r <= cfg_wdata;
        REG_SHIFT_Y: shy_r <= cfg_wdata;
        REG_SHIFT_Z: shz_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  qrvt_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mat_hi    (mat_hi),
    .mat_lo    (mat_lo)
  );

  assign vtx[0] = s1_r.vertex_x;
  assign vtx[1] = s1_r.vertex_y;
  assign vtx[2] = s1_r.vertex_z;

  assign en.mul = rdy[2];
  assign en.sum = rdy[3];
  assign en.fin = rdy[4];

  qrvt_row u_row_x (
    .clk   (clk),
    .en    (en),
    .mhi   (mat_hi[0]),
    .mlo   (mat_lo[0]),
    .vtx   (vtx),
    .shift (shx_r),
    .moved (mv_x),
    .clip  (cl_x)
  );

  qrvt_row u_row_y (
    .clk   (clk),
    .en    (en),
    .mhi   (mat_hi[1]),
    .mlo   (mat_lo[1]),
    .vtx   (vtx),
    .shift (shy_r),
    .moved (mv_y),
    .clip  (cl_y)
  );

  qrvt_row u_row_z (
    .clk   (clk),
    .en    (en),
    .mhi   (mat_hi[2]),
    .mlo   (mat_lo[2]),
    .vtx   (vtx),
    .shift (shz_r),
    .moved (mv_z),
    .clip  (cl_z)
  );

  assign in_stall          = !rdy[0];
  assign out_valid         = vld_r[NSTG-1];
  assign out_data.moved_x  = mv_x;
  assign out_data.moved_y  = mv_y;
  assign out_data.moved_z  = mv_z;
  assign out_data.clipped  = cl_x | cl_y | cl_z;

  // stalling the input only happens with every stage full
  `ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, &vld_r)
  // a full multiply stage that cannot move keeps its item
  `ASSERT_NEXT(a_hold_mid, clk, rst_n, vld_r[2] && !rdy[2], vld_r[2])
  // a new result comes from the stage before the output
  `ASSERT_IMPL(a_out_src, clk, rst_n, $rose(vld_r[NSTG-1]), $past(vld_r[NSTG-2]))
  // a full output stage held by out_stall keeps its item
  `ASSERT_NEXT(a_out_hold, clk, rst_n, vld_r[NSTG-1] && out_stall, vld_r[NSTG-1])

endmodule

/* verif/quaternion_rigid_vertex_transform_checker.sv */
// checker of the vertex transform: predicts each transformed vertex and compares results
`timescale 1ns / 1ps

module quaternion_rigid_vertex_transform_checker import qrvt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  vtx_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  vtx_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0] cfg_wdata,
  output int                 errors,
  output int                 pending,
  output int                 results,
  output int                 clipped_count
);

  logic signed [QUAT_W-1:0]  quat_r[4];
  logic signed [COORD_W-1:0] shift_r[3];
  vtx_out_t                  due_q[$];

  initial begin
    errors        = 0;
    pending       = 0;
    results       = 0;
    clipped_count = 0;
  end

  // exact R*v in wide signed arithmetic, rounded half up, then shifted and clamped
  function automatic vtx_out_t transform_vertex(vtx_in_t v);
    logic signed [127:0] qw, qx, qy, qz, one, acc;
    logic signed [127:0] m[3][3];
    logic signed [127:0] vv[3];
    logic [COORD_W-1:0]  c[3];
    logic                clip;
    vtx_out_t            res;
    int                  i;
    qw  = 128'(quat_r[0]);
    qx  = 128'(quat_r[1]);
    qy  = 128'(quat_r[2]);
    qz  = 128'(quat_r[3]);
    one = 128'sd1 <<< 32;
    m[0][0] = one - 2 * (qy * qy + qz * qz);
    m[0][1] = 2 * (qx * qy - qz * qw);
    m[0][2] = 2 * (qx * qz + qy * qw);
    m[1][0] = 2 * (qx * qy + qz * qw);
    m[1][1] = one - 2 * (qx * qx + qz * qz);
    m[1][2] = 2 * (qy * qz - qx * qw);
    m[2][0] = 2 * (qx * qz - qy * qw);
    m[2][1] = 2 * (qy * qz + qx * qw);
    m[2][2] = one - 2 * (qx * qx + qy * qy);
    vv[0] = 128'(v.vertex_x);
    vv[1] = 128'(v.vertex_y);
    vv[2] = 128'(v.vertex_z);
    clip  = 1'b0;
    for (i = 0; i < 3; i++) begin
      acc = m[i][0] * vv[0] + m[i][1] * vv[1] + m[i][2] * vv[2];
      acc = (acc + (128'sd1 <<< 31)) >>> 32;
      acc = acc + 128'(shift_r[i]);
      if (acc > 128'sd2147483647) begin
        acc  = 128'sd2147483647;
        clip = 1'b1;
      end else if (acc < -128'sd2147483648) begin
        acc  = -128'sd2147483648;
        clip = 1'b1;
      end
      c[i] = acc[COORD_W-1:0];
    end
    res.moved_x = c[0];
    res.moved_y = c[1];
    res.moved_z = c[2];
    res.clipped = clip;
    return res;
  endfunction

  task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    vtx_out_t want;
    if (!rst_n) begin
      quat_r[0]  = QUAT_W_RST;
      quat_r[1]  = '0;
      quat_r[2]  = '0;
      quat_r[3]  = '0;
      shift_r[0] = '0;
      shift_r[1] = '0;
      shift_r[2] = '0;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("result item with no vertex waiting for it");
          errors++;
        end else begin
          want = due_q.pop_front();
          check_field("moved_x", want.moved_x, out_data.moved_x);
          check_field("moved_y", want.moved_y, out_data.moved_y);
          check_field("moved_z", want.moved_z, out_data.moved_z);
          check_field("clipped", {31'b0, want.clipped}, {31'b0, out_data.clipped});
          results++;
          if (want.clipped) clipped_count++;
        end
      end
      if (in_valid && !in_stall) due_q.push_back(transform_vertex(in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_QUAT_W:  quat_r[0]  = cfg_wdata[QUAT_W-1:0];
          REG_QUAT_X:  quat_r[1]  = cfg_wdata[QUAT_W-1:0];
          REG_QUAT_Y:  quat_r[2]  = cfg_wdata[QUAT_W-1:0];
          REG_QUAT_Z:  quat_r[3]  = cfg_wdata[QUAT_W-1:0];
          REG_SHIFT_X: shift_r[0] = cfg_wdata;
          REG_SHIFT_Y: shift_r[1] = cfg_wdata;
          REG_SHIFT_Z: shift_r[2] = cfg_wdata;
          default: ;  // unknown index, write dropped
        endcase
      end
    end
    pending = due_q.size();
  end

endmodule

/* verif/quaternion_rigid_vertex_transform_tb.sv */
// testbench top of the vertex transform: vertex stimulus, register settings and verdict
`timescale 1ns / 1ps

module quaternion_rigid_vertex_transform_tb;
  import qrvt_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN        = 12;
  localparam int LIMIT        = 500000;
  localparam int BATCHES      = 10;
  localparam int BATCH_ITEMS  = 65;
  localparam logic [CIDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [COORD_W-1:0] C_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  vtx_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  vtx_out_t           out_data;
  logic               cfg_we    = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;

  int errors, pending, results, clipped_count;
  int cycle_cnt = 0;
  int sent      = 0;
  int settings  = 0;
  bit calm      = 1'b0;

  logic signed [QUAT_W-1:0]  quat_set[4];
  logic signed [COORD_W-1:0] shift_set[3];

  always #(CLK_HALF) clk = ~clk;

  quaternion_rigid_vertex_transform u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  quaternion_rigid_vertex_transform_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending),
    .results       (results),
    .clipped_count (clipped_count)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("[quaternion_rigid_vertex_transform] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (r < 8) return $urandom();
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return 32'h0;
      3: return 32'h1;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  initial begin : stall_gen
    int n;
    @(posedge rst_n);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  task automatic send_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {x, y, z};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // stop feeding and let every result come out
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // quaternion writes carry junk in the bits above the register width
  task automatic apply_setting();
    write_reg(REG_QUAT_W, {14'($urandom()), quat_set[0]});
    write_reg(REG_QUAT_X, {14'($urandom()), quat_set[1]});
    write_reg(REG_QUAT_Y, {14'($urandom()), quat_set[2]});
    write_reg(REG_QUAT_Z, {14'($urandom()), quat_set[3]});
    write_reg(REG_SHIFT_X, shift_set[0]);
    write_reg(REG_SHIFT_Y, shift_set[1]);
    write_reg(REG_SHIFT_Z, shift_set[2]);
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, $urandom());
    // let the matrix rebuild settle
    repeat (4) @(negedge clk);
    settings++;
  endtask

  task automatic random_rotation(real scale);
    real c[4];
    real n;
    int  i;
    for (i = 0; i < 4; i++) c[i] = real'($urandom_range(0, 131072)) - 65536.0;
    n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    if (n < 1.0) begin
      c[0] = 1.0;
      n    = 1.0;
    end
    for (i = 0; i < 4; i++) quat_set[i] = 18'($rtoi(c[i] / n * 65536.0 * scale));
  endtask

  task automatic random_setting();
    int r;
    int i;
    r = $urandom_range(0, 19);
    if (r < 10) begin
      random_rotation(1.0);
      for (i = 0; i < 3; i++)
        shift_set[i] = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    end else if (r < 14) begin
      for (i = 0; i < 4; i++) quat_set[i] = 18'($urandom());
      for (i = 0; i < 3; i++) shift_set[i] = $urandom();
    end else if (r < 17) begin
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: quat_set[i] = 18'h1ffff;
          1: quat_set[i] = 18'h20000;
          2: quat_set[i] = 18'h0;
          default: quat_set[i] = 18'h10000;
        endcase
      end
      for (i = 0; i < 3; i++) begin
        case ($urandom_range(0, 2))
          0: shift_set[i] = C_MAX;
          1: shift_set[i] = C_MIN;
          default: shift_set[i] = '0;
        endcase
      end
    end else begin
      // non-unit quaternion: scales as well as rotates
      random_rotation(0.5 + real'($urandom_range(0, 140)) / 100.0);
      for (i = 0; i < 3; i++) shift_set[i] = $urandom();
    end
  endtask

  initial begin : stimulus
    int b;
    int k;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: identity rotation, no shift
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN);
    send_vertex(32'h1, 32'hffff_ffff, 32'h0001_0000);
    quiesce();

    // identity with extreme shifts, saturation on both sides
    quat_set  = '{18'h10000, 18'h0, 18'h0, 18'h0};
    shift_set = '{C_MAX, C_MIN, 32'h1234_5678};
    apply_setting();
    send_vertex(C_MAX, C_MIN, 32'h0);
    send_vertex(C_MIN, C_MAX, C_MAX);
    send_vertex(32'hffff_ffff, 32'h1, 32'h0);
    send_vertex(C_MAX, C_MAX, C_MIN);
    quiesce();

    // x and y at half scale: rounding ties go toward plus infinity
    quat_set  = '{18'h0, 18'h0, 18'h0, 18'h08000};
    shift_set = '{32'h0, 32'h0, 32'h0};
    apply_setting();
    send_vertex(32'h1, 32'h1, 32'h1);
    send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vertex(32'h3, 32'hffff_fffd, C_MIN);
    quiesce();

    // largest quaternion, strong scaling
    quat_set = '{18'h1ffff, 18'h1ffff, 18'h1ffff, 18'h1ffff};
    apply_setting();
    send_vertex(C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN);
    send_vertex(C_MAX, 32'h0, C_MIN);
    quiesce();

    // most negative quaternion with extreme shifts
    quat_set  = '{18'h20000, 18'h20000, 18'h20000, 18'h20000};
    shift_set = '{C_MIN, C_MAX, 32'h0};
    apply_setting();
    send_vertex(C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN);
    send_vertex(32'h1, 32'h0, 32'hffff_ffff);
    quiesce();

    // quarter turn about z
    quat_set  = '{18'd46341, 18'h0, 18'h0, 18'd46341};
    shift_set = '{32'h0001_0000, 32'hffff_0000, 32'h0};
    apply_setting();
    send_vertex(32'h0001_0000, 32'h0, 32'h0);
    send_vertex(32'h0, 32'h0001_0000, 32'h0001_0000);
    quiesce();

    for (b = 0; b < BATCHES; b++) begin
      calm = ($urandom_range(0, 3) == 0);
      random_setting();
      apply_setting();
      for (k = 0; k < BATCH_ITEMS; k++) send_vertex(pick_coord(), pick_coord(), pick_coord());
      quiesce();
    end
    calm = 1'b0;

    $display("sent %0d vertices under %0d register settings", sent, settings);
    $display("checked %0d results, %0d of them saturated", results, clipped_count);
    if (errors == 0 && pending == 0) begin
      $display("[quaternion_rigid_vertex_transform] OK");
    end else begin
      $display("[quaternion_rigid_vertex_transform] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qrvt_pkg.sv
rtl/qrvt_matrix.sv
rtl/qrvt_row.sv
rtl/quaternion_rigid_vertex_transform.sv
verif/quaternion_rigid_vertex_transform_checker.sv
verif/quaternion_rigid_vertex_transform_tb.sv
